/* rtl/core/nai_pkg.sv */
// Shared types and constants of the node attraction integrator.
// Used by every module of the block; depends on nothing.
package nai_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;

    localparam logic OP_ATTRACT   = 1'b0;
    localparam logic OP_INTEGRATE = 1'b1;

    typedef enum logic [1:0] {
        REG_STRENGTH  = 2'd0,
        REG_RAMP      = 2'd1,
        REG_MAX_SPEED = 2'd2,
        REG_DAMPING   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] attractor_x;
        logic signed [31:0] attractor_y;
        logic [30:0]        attractor_radius;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] node_vx;
        logic signed [31:0] node_vy;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_vx;
        logic signed [31:0] new_vy;
        logic               force_applied;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [15:0] strength;
        logic [15:0]        ramp;
        logic [30:0]        max_speed;
        logic [15:0]        damping;
    } t_cfg;

    // classified item as it waits in the queue
    typedef struct packed {
        logic               op;
        logic               inr;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [30:0]        radius;
    } t_job;

    typedef struct packed {
        logic           push;
        logic           pop;
        logic           full;
        logic [QAW:0]   count;
    } t_qstat;

    // Q0.30 root of one half taken iters times, each root floored
    function automatic logic [29:0] exp_root(input int iters);
        logic [63:0] r;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        r = 64'd1 << 29;
        for (int it = 0; it < iters; it++) begin
            n   = r << 30;
            res = 64'd0;
            b   = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (n >= res + b) begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            r = res;
        end
        return r[29:0];
    endfunction

endpackage

/* rtl/core/nai_front.sv */
// Front end: accepts items, forms the attractor offsets and the range flag.
// Depends on nai_pkg.
module nai_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nai_pkg::t_in   i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output nai_pkg::t_job  o_job
);

    logic          r_vld;
    nai_pkg::t_job r_job;
    nai_pkg::t_job n_job;
    logic [32:0]   w_dx;
    logic [32:0]   w_dy;
    logic          w_xok;
    logic          w_yok;

    assign w_dx  = {i_item.attractor_x[31], i_item.attractor_x}
                 - {i_item.node_x[31], i_item.node_x};
    assign w_dy  = {i_item.attractor_y[31], i_item.attractor_y}
                 - {i_item.node_y[31], i_item.node_y};
    // offset must stay strictly inside +-2^31
    assign w_xok = (w_dx[32] == w_dx[31]) && (w_dx != 33'h1_8000_0000);
    assign w_yok = (w_dy[32] == w_dy[31]) && (w_dy != 33'h1_8000_0000);

    always_comb begin
        n_job.op     = i_item.operation;
        n_job.inr    = w_xok && w_yok;
        n_job.nx     = i_item.node_x;
        n_job.ny     = i_item.node_y;
        n_job.vx     = i_item.node_vx;
        n_job.vy     = i_item.node_vy;
        n_job.dx     = w_dx[31:0];
        n_job.dy     = w_dy[31:0];
        n_job.radius = i_item.attractor_radius;
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

/* rtl/core/nai_queue.sv */
// Short queue between front end and datapath.
// Depends on nai_pkg for the item type and depth.
module nai_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  nai_pkg::t_job    i_job,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output nai_pkg::t_job    o_job,
    output nai_pkg::t_qstat  o_stat
);

    nai_pkg::t_job             r_mem [nai_pkg::QDEPTH];
    logic [nai_pkg::QAW-1:0]   r_wr;
    logic [nai_pkg::QAW-1:0]   r_rd;
    logic [nai_pkg::QAW:0]     r_cnt;
    logic                      w_full;
    logic                      w_push;
    logic                      w_pop;

    assign w_full       = (r_cnt == (nai_pkg::QAW + 1)'(nai_pkg::QDEPTH));
    assign o_push_ready = !w_full;
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && !w_full;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_job        = r_mem[r_rd];

    assign o_stat.push  = w_push;
    assign o_stat.pop   = w_pop;
    assign o_stat.full  = w_full;
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (nai_pkg::QAW + 1)'(w_push) - (nai_pkg::QAW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/core/nai_back.sv */
// Datapath: square root, divisions, log2/exp2 curve, force and limits,
// one bit or one multiply per stage. Depends on nai_pkg.
module nai_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nai_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  nai_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output nai_pkg::t_out  o_item
);

    localparam int SQ_STEPS = 32;
    localparam int QD_STEPS = 32;
    localparam int LG_STEPS = 16;
    localparam int ED_STEPS = 30;
    localparam int EX_STEPS = 16;
    localparam int GD_STEPS = 17;
    localparam int LD_STEPS = 63;

    localparam int S_SQ  = 1;
    localparam int S_CHK = S_SQ + SQ_STEPS;
    localparam int S_QD  = S_CHK + 1;
    localparam int S_LZ  = S_QD + QD_STEPS;
    localparam int S_LG  = S_LZ + 1;
    localparam int S_EP  = S_LG + LG_STEPS;
    localparam int S_ED  = S_EP + 1;
    localparam int S_EX  = S_ED + ED_STEPS;
    localparam int S_SH  = S_EX + EX_STEPS;
    localparam int S_GD  = S_SH + 1;
    localparam int S_M1  = S_GD + GD_STEPS;
    localparam int S_M2  = S_M1 + 1;
    localparam int S_M3  = S_M2 + 1;
    localparam int S_KP  = S_M3 + 1;
    localparam int S_PR  = S_KP + 1;
    localparam int S_LD  = S_PR + 1;
    localparam int S_F1  = S_LD + LD_STEPS;
    localparam int S_F2  = S_F1 + 1;
    localparam int NST   = S_F2 + 1;

    typedef struct packed {
        logic               vld;
        logic               op;
        logic               inr;
        logic               app;
        logic               lim;
        logic               kneg;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [30:0]        radius;
        logic [63:0]        sqn;
        logic [35:0]        sqr;
        logic [31:0]        dlen;
        logic [31:0]        qr;
        logic [31:0]        q;
        logic [4:0]         msb;
        logic [31:0]        lx;
        logic [15:0]        frac;
        logic [29:0]        en;
        logic [15:0]        er;
        logic [30:0]        y;
        logic [16:0]        s16;
        logic [15:0]        gt;
        logic [18:0]        gr;
        logic [16:0]        gq;
        logic signed [35:0] p1;
        logic signed [39:0] p2;
        logic signed [55:0] p3;
        logic [31:0]        kmag;
        logic [1:0][62:0]   ln;
        logic [1:0][31:0]   lr;
        logic [1:0]         lneg;
        logic [31:0]        ldiv;
        logic [1:0][48:0]   dmp;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] ovx;
        logic signed [31:0] ovy;
        logic               fa;
        logic               sat;
    } t_ctx;

    t_ctx r_st [NST];
    t_ctx n_st [NST];
    logic w_adv;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // {clip flag, value}
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic t_ctx f_load(input nai_pkg::t_job j, input logic vld);
        t_ctx o;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        o        = '0;
        o.vld    = vld;
        o.op     = j.op;
        o.inr    = j.inr;
        o.nx     = j.nx;
        o.ny     = j.ny;
        o.vx     = j.vx;
        o.vy     = j.vy;
        o.dx     = j.dx;
        o.dy     = j.dy;
        o.radius = j.radius;
        if (j.op == nai_pkg::OP_INTEGRATE) begin
            a = j.vx;
            b = j.vy;
        end else if (j.inr) begin
            a = j.dx;
            b = j.dy;
        end else begin
            a = '0;
            b = '0;
        end
        pa    = a * a;
        pb    = b * b;
        o.sqn = $unsigned(pa) + $unsigned(pb);
        return o;
    endfunction

    function automatic t_ctx f_sq(input t_ctx c);
        t_ctx o;
        logic [35:0] t;
        logic [35:0] trial;
        o     = c;
        t     = {c.sqr[33:0], c.sqn[63:62]};
        trial = {2'b00, c.dlen, 2'b01};
        if (t >= trial) begin
            o.sqr  = t - trial;
            o.dlen = {c.dlen[30:0], 1'b1};
        end else begin
            o.sqr  = t;
            o.dlen = {c.dlen[30:0], 1'b0};
        end
        o.sqn = {c.sqn[61:0], 2'b00};
        return o;
    endfunction

    function automatic t_ctx f_chk(input t_ctx c, input nai_pkg::t_cfg cfg);
        t_ctx o;
        o     = c;
        o.app = (c.op == nai_pkg::OP_ATTRACT) && c.inr && (c.dlen != '0)
              && (c.dlen < {1'b0, c.radius});
        o.lim = (c.op == nai_pkg::OP_INTEGRATE) && (c.dlen > {1'b0, cfg.max_speed});
        o.qr  = c.dlen;
        o.q   = '0;
        return o;
    endfunction

    // ratio dlen/radius as Q0.32, dlen below radius
    function automatic t_ctx f_qd(input t_ctx c);
        t_ctx o;
        logic [32:0] t;
        o = c;
        t = {c.qr, 1'b0};
        if (t >= {2'b00, c.radius}) begin
            o.qr = 32'(t - {2'b00, c.radius});
            o.q  = {c.q[30:0], 1'b1};
        end else begin
            o.qr = t[31:0];
            o.q  = {c.q[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_ctx f_lz(input t_ctx c);
        t_ctx o;
        logic [4:0] m;
        o = c;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            if (c.q[i]) begin
                m = 5'(i);
            end
        end
        o.msb  = m;
        o.lx   = c.q << (5'd31 - m);
        o.frac = '0;
        return o;
    endfunction

    function automatic t_ctx f_lg(input t_ctx c);
        t_ctx o;
        logic [63:0] pr;
        logic [32:0] x;
        o  = c;
        pr = 64'(c.lx) * 64'(c.lx);
        x  = pr[63:31];
        if (x[32]) begin
            o.frac = {c.frac[14:0], 1'b1};
            o.lx   = x[32:1];
        end else begin
            o.frac = {c.frac[14:0], 1'b0};
            o.lx   = x[31:0];
        end
        return o;
    endfunction

    // magnitude of the Q.16 log, times 256, into the ramp divider
    function automatic t_ctx f_ep(input t_ctx c);
        t_ctx o;
        logic [21:0] alr;
        o    = c;
        alr  = {6'd32 - {1'b0, c.msb}, 16'd0} - {6'd0, c.frac};
        o.en = {alr, 8'd0};
        o.er = '0;
        o.y  = 31'd1 << 30;
        return o;
    endfunction

    function automatic t_ctx f_ed(input t_ctx c, input nai_pkg::t_cfg cfg);
        t_ctx o;
        logic [15:0] rv;
        logic [16:0] t;
        o  = c;
        rv = (cfg.ramp == '0) ? 16'd1 : cfg.ramp;
        t  = {c.er, c.en[29]};
        if (t >= {1'b0, rv}) begin
            o.er = 16'(t - {1'b0, rv});
            o.en = {c.en[28:0], 1'b1};
        end else begin
            o.er = t[15:0];
            o.en = {c.en[28:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_ctx f_ex(input t_ctx c, input logic [29:0] root, input int k);
        t_ctx o;
        logic [60:0] pr;
        o = c;
        if (c.en[k]) begin
            pr  = 61'(c.y) * 61'(root);
            o.y = pr[60:30];
        end
        return o;
    endfunction

    function automatic t_ctx f_sh(input t_ctx c);
        t_ctx o;
        logic [30:0] yy;
        logic [17:0] t3;
        o  = c;
        yy = (c.en[29:16] >= 14'd31) ? 31'd0 : (c.y >> c.en[20:16]);
        o.s16 = yy[30:14];
        t3    = 18'd196608 - {1'b0, yy[30:14]};
        o.gt  = t3[17:2];
        o.gr  = 19'd32768;
        o.gq  = '0;
        return o;
    endfunction

    // 2^32 / (s16 + 1.0), quotient bits above 2^16 are zero
    function automatic t_ctx f_gd(input t_ctx c);
        t_ctx o;
        logic [17:0] den;
        logic [18:0] t;
        o   = c;
        den = {1'b0, c.s16} + 18'd65536;
        t   = {c.gr[17:0], 1'b0};
        if (t >= {1'b0, den}) begin
            o.gr = t - {1'b0, den};
            o.gq = {c.gq[15:0], 1'b1};
        end else begin
            o.gr = t;
            o.gq = {c.gq[15:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_ctx f_m1(input t_ctx c);
        t_ctx o;
        logic signed [17:0] g;
        logic signed [17:0] s;
        o    = c;
        g    = $signed({1'b0, c.gq}) - $signed({2'b00, c.gt});
        s    = $signed({1'b0, c.s16});
        o.p1 = s * g;
        return o;
    endfunction

    function automatic t_ctx f_m2(input t_ctx c);
        t_ctx o;
        logic signed [39:0] w;
        o    = c;
        w    = {{4{c.p1[35]}}, c.p1};
        o.p2 = (w <<< 3) + w;
        return o;
    endfunction

    function automatic t_ctx f_m3(input t_ctx c, input nai_pkg::t_cfg cfg);
        t_ctx o;
        o    = c;
        o.p3 = c.p2 * cfg.strength;
        return o;
    endfunction

    function automatic t_ctx f_kp(input t_ctx c);
        t_ctx o;
        logic signed [55:0] kf;
        o      = c;
        kf     = c.p3 >>> (40 - nai_pkg::FRAC_BITS);
        o.kneg = kf[55];
        o.kmag = mag32(kf[31:0]);
        return o;
    endfunction

    // both lanes: magnitude times scale, ready for the long division
    function automatic t_ctx f_pr(input t_ctx c, input nai_pkg::t_cfg cfg);
        t_ctx o;
        logic [1:0][31:0] src;
        logic [31:0]      a;
        logic [31:0]      mul;
        logic [63:0]      pr;
        o = c;
        if (c.op == nai_pkg::OP_INTEGRATE) begin
            src[0] = c.vx;
            src[1] = c.vy;
            mul    = c.lim ? {1'b0, cfg.max_speed} : 32'd1;
            o.ldiv = c.lim ? c.dlen : 32'd1;
        end else begin
            src[0] = c.dx;
            src[1] = c.dy;
            mul    = c.kmag;
            o.ldiv = c.dlen;
        end
        for (int i = 0; i < 2; i++) begin
            a         = mag32(src[i]);
            pr        = 64'(a) * 64'(mul);
            o.ln[i]   = pr[62:0];
            o.lr[i]   = '0;
            o.lneg[i] = src[i][31];
        end
        return o;
    endfunction

    function automatic t_ctx f_ld(input t_ctx c);
        t_ctx o;
        logic [32:0] t;
        o = c;
        for (int i = 0; i < 2; i++) begin
            t = {c.lr[i], c.ln[i][62]};
            if (t >= {1'b0, c.ldiv}) begin
                o.lr[i] = 32'(t - {1'b0, c.ldiv});
                o.ln[i] = {c.ln[i][61:0], 1'b1};
            end else begin
                o.lr[i] = t[31:0];
                o.ln[i] = {c.ln[i][61:0], 1'b0};
            end
        end
        return o;
    endfunction

    function automatic t_ctx f_f1(input t_ctx c, input nai_pkg::t_cfg cfg);
        t_ctx o;
        logic [1:0][31:0] vin;
        logic [1:0][31:0] pin;
        logic [1:0][32:0] res;
        logic [16:0]      keep;
        logic [63:0]      qs;
        logic [63:0]      dv;
        logic [65:0]      sum;
        o      = c;
        keep   = 17'h1_0000 - {1'b0, cfg.damping};
        vin[0] = c.vx;
        vin[1] = c.vy;
        pin[0] = c.nx;
        pin[1] = c.ny;
        for (int i = 0; i < 2; i++) begin
            qs = {1'b0, c.ln[i]};
            if (c.op == nai_pkg::OP_INTEGRATE) begin
                dv       = c.lneg[i] ? 64'(-qs) : qs;
                sum      = {{34{pin[i][31]}}, pin[i]} + {{2{dv[63]}}, dv};
                res[i]   = sat32($signed(sum));
                o.dmp[i] = 49'(c.ln[i][31:0]) * 49'(keep);
            end else begin
                dv       = (c.lneg[i] ^ c.kneg) ? 64'(-qs) : qs;
                sum      = {{34{vin[i][31]}}, vin[i]} + {{2{dv[63]}}, dv};
                res[i]   = c.app ? sat32($signed(sum)) : {1'b0, vin[i]};
            end
        end
        if (c.op == nai_pkg::OP_INTEGRATE) begin
            o.ox = res[0][31:0];
            o.oy = res[1][31:0];
        end else begin
            o.ox  = c.nx;
            o.oy  = c.ny;
            o.ovx = res[0][31:0];
            o.ovy = res[1][31:0];
        end
        o.sat = res[0][32] | res[1][32];
        o.fa  = c.app;
        return o;
    endfunction

    // damping scale on the limited velocity
    function automatic t_ctx f_f2(input t_ctx c);
        t_ctx o;
        logic [1:0][32:0] res;
        logic [63:0]      qs;
        logic [63:0]      dv;
        o = c;
        if (c.op == nai_pkg::OP_INTEGRATE) begin
            for (int i = 0; i < 2; i++) begin
                qs     = {31'd0, c.dmp[i][48:16]};
                dv     = c.lneg[i] ? 64'(-qs) : qs;
                res[i] = sat32($signed({{2{dv[63]}}, dv}));
            end
            o.ovx = res[0][31:0];
            o.ovy = res[1][31:0];
            o.sat = c.sat | res[0][32] | res[1][32];
        end
        return o;
    endfunction

    assign w_adv   = !r_st[NST-1].vld || i_ready;
    assign o_ready = w_adv;

    assign n_st[0] = f_load(i_job, i_valid);

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        assign n_st[S_SQ+j] = f_sq(r_st[S_SQ+j-1]);
    end

    assign n_st[S_CHK] = f_chk(r_st[S_CHK-1], i_cfg);

    for (genvar j = 0; j < QD_STEPS; j++) begin : g_qd
        assign n_st[S_QD+j] = f_qd(r_st[S_QD+j-1]);
    end

    assign n_st[S_LZ] = f_lz(r_st[S_LZ-1]);

    for (genvar j = 0; j < LG_STEPS; j++) begin : g_lg
        assign n_st[S_LG+j] = f_lg(r_st[S_LG+j-1]);
    end

    assign n_st[S_EP] = f_ep(r_st[S_EP-1]);

    for (genvar j = 0; j < ED_STEPS; j++) begin : g_ed
        assign n_st[S_ED+j] = f_ed(r_st[S_ED+j-1], i_cfg);
    end

    for (genvar j = 0; j < EX_STEPS; j++) begin : g_ex
        localparam logic [29:0] ROOT = nai_pkg::exp_root(j + 1);
        assign n_st[S_EX+j] = f_ex(r_st[S_EX+j-1], ROOT, EX_STEPS - 1 - j);
    end

    assign n_st[S_SH] = f_sh(r_st[S_SH-1]);

    for (genvar j = 0; j < GD_STEPS; j++) begin : g_gd
        assign n_st[S_GD+j] = f_gd(r_st[S_GD+j-1]);
    end

    assign n_st[S_M1] = f_m1(r_st[S_M1-1]);
    assign n_st[S_M2] = f_m2(r_st[S_M2-1]);
    assign n_st[S_M3] = f_m3(r_st[S_M3-1], i_cfg);
    assign n_st[S_KP] = f_kp(r_st[S_KP-1]);
    assign n_st[S_PR] = f_pr(r_st[S_PR-1], i_cfg);

    for (genvar j = 0; j < LD_STEPS; j++) begin : g_ld
        assign n_st[S_LD+j] = f_ld(r_st[S_LD+j-1]);
    end

    assign n_st[S_F1] = f_f1(r_st[S_F1-1], i_cfg);
    assign n_st[S_F2] = f_f2(r_st[S_F2-1]);

    // whole pipe holds while the last stage waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_st[i].vld <= 1'b0;
            end
        end else if (w_adv) begin
            for (int i = 0; i < NST; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_valid              = r_st[NST-1].vld;
    assign o_item.new_x         = r_st[NST-1].ox;
    assign o_item.new_y         = r_st[NST-1].oy;
    assign o_item.new_vx        = r_st[NST-1].ovx;
    assign o_item.new_vy        = r_st[NST-1].ovy;
    assign o_item.force_applied = r_st[NST-1].fa;
    assign o_item.saturated     = r_st[NST-1].sat;

endmodule

/* rtl/core/node_attraction_integrator_top.sv */
// Node attraction integrator: front register, queue and datapath pipeline from input accept to
// result valid; one item per cycle sustained while the output is not stalled, set by the
// fully pipelined datapath (one root, quotient bit or multiply per stage).
// Reset (synchronous, active low) empties front register, queue and pipeline
// and loads the register defaults; no clearing pass.
module node_attraction_integrator_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nai_pkg::t_in   i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nai_pkg::t_out  o_out_item,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    nai_pkg::t_cfg   r_cfg;
    nai_pkg::t_job   w_fjob;
    nai_pkg::t_job   w_qjob;
    nai_pkg::t_qstat w_qstat;
    logic            w_fvalid;
    logic            w_fready;
    logic            w_qvalid;
    logic            w_bready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strength  <= -16'sd256;
            r_cfg.ramp      <= 16'd256;
            r_cfg.max_speed <= 31'd655360;
            r_cfg.damping   <= 16'd6554;
        end else if (i_cfg_valid) begin
            case (nai_pkg::t_reg_idx'(i_cfg_index))
                nai_pkg::REG_STRENGTH:  r_cfg.strength  <= i_cfg_data[15:0];
                nai_pkg::REG_RAMP:      r_cfg.ramp      <= i_cfg_data[15:0];
                nai_pkg::REG_MAX_SPEED: r_cfg.max_speed <= i_cfg_data[30:0];
                nai_pkg::REG_DAMPING:   r_cfg.damping   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    nai_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_fvalid),
        .i_ready (w_fready),
        .o_job   (w_fjob)
    );

    nai_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fvalid),
        .o_push_ready (w_fready),
        .i_job        (w_fjob),
        .o_pop_valid  (w_qvalid),
        .i_pop_ready  (w_bready),
        .o_job        (w_qjob),
        .o_stat       (w_qstat)
    );

    nai_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_qvalid),
        .o_ready (w_bready),
        .i_job   (w_qjob),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_qstat.pop)
        else $error("queue popped while the result is stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= (nai_pkg::QAW + 1)'(nai_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qstat.push && !w_qstat.pop) |=> (w_qstat.count == $past(w_qstat.count) + 1'b1))
        else $error("queue count lost a push");

endmodule
